[rtl/rate_limited_thrust_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rate limited thrust allocator
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef RATE_LIMITED_THRUST_ALLOCATOR_MACROS_SVH
`define RATE_LIMITED_THRUST_ALLOCATOR_MACROS_SVH

// Checked only while out of reset.
`define RTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RTA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rta_pkg.sv]
// ----------------------------------------------------------------------------
// rta_pkg
// Types, register indexes and limits shared by the thrust allocator modules.
// ----------------------------------------------------------------------------
package rta_pkg;

    localparam int MAX_THRUSTERS      = 4;
    localparam int THRUSTER_COUNT_DEF = 4;
    localparam int PIPE_STAGES        = 5;

    localparam int THRUST_W   = 24;
    localparam int RATE_W     = 23;
    localparam int COEF_W     = 18;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam int SAT_CNT_W  = 4;

    typedef logic signed [THRUST_W-1:0] thrust_t;
    typedef logic        [RATE_W-1:0]   rate_t;
    typedef logic        [ROW_W-1:0]    coef_row_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    localparam thrust_t THRUST_MAX = 24'sh7FFFFF;
    localparam thrust_t THRUST_MIN = -24'sh800000;
    localparam rate_t   RATE_MAX   = 23'h7FFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_3 = 3'd6;

    typedef struct packed {
        rate_t   rate_limit;
        thrust_t floor;
        thrust_t ceiling;
    } limits_t;

    // stage advance enables handed to each lane
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_ctl_t;

endpackage

[rtl/rta_cfg.sv]
// ----------------------------------------------------------------------------
// rta_cfg
// Configuration register file: limits and pseudo-inverse rows.
// ----------------------------------------------------------------------------
module rta_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [rta_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [rta_pkg::CFG_DATA_W-1:0]      wr_data,
    output rta_pkg::limits_t                    limits,
    output rta_pkg::coef_row_t                  coef_rows [rta_pkg::MAX_THRUSTERS]
);
    import rta_pkg::*;

    limits_t   limits_reg;
    coef_row_t rows_reg [MAX_THRUSTERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.rate_limit <= RATE_MAX;
            limits_reg.floor      <= THRUST_MIN;
            limits_reg.ceiling    <= THRUST_MAX;
            for (int i = 0; i < MAX_THRUSTERS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RATE_LIMIT: limits_reg.rate_limit <= wr_data[RATE_W-1:0];
                REG_FLOOR:      limits_reg.floor      <= signed'(wr_data[THRUST_W-1:0]);
                REG_CEILING:    limits_reg.ceiling    <= signed'(wr_data[THRUST_W-1:0]);
                REG_COEF_ROW_0: rows_reg[0]           <= wr_data[ROW_W-1:0];
                REG_COEF_ROW_1: rows_reg[1]           <= wr_data[ROW_W-1:0];
                REG_COEF_ROW_2: rows_reg[2]           <= wr_data[ROW_W-1:0];
                REG_COEF_ROW_3: rows_reg[3]           <= wr_data[ROW_W-1:0];
                default:        ;
            endcase
        end
    end

    assign limits    = limits_reg;
    assign coef_rows = rows_reg;

endmodule

[rtl/rta_lane.sv]
// ----------------------------------------------------------------------------
// rta_lane
// One thruster: products, rounded sum, rate limit, box clamp (four stages).
// ----------------------------------------------------------------------------
module rta_lane (
    input  logic                   clk,
    input  rta_pkg::pipe_ctl_t     ctl,
    input  rta_pkg::coef_row_t     coef_row,
    input  rta_pkg::limits_t       limits,
    input  rta_pkg::thrust_t       wrench_surge,
    input  rta_pkg::thrust_t       wrench_sway,
    input  rta_pkg::thrust_t       wrench_yaw,
    input  rta_pkg::thrust_t       prev_thrust,
    output rta_pkg::thrust_t       thrust,
    output logic [1:0]             sat_cnt
);
    import rta_pkg::*;

    localparam int PROD_W = COEF_W + THRUST_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = SUM_W - 16;
    localparam int DLT_W  = THRUST_W + 1;
    localparam int RL_W   = THRUST_W + 2;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

    // stage 1: products
    coef_t c_surge, c_sway, c_yaw;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    thrust_t prev1_reg;

    assign c_surge = signed'(coef_row[COEF_W-1:0]);
    assign c_sway  = signed'(coef_row[2*COEF_W-1:COEF_W]);
    assign c_yaw   = signed'(coef_row[3*COEF_W-1:2*COEF_W]);
    assign p0_next = c_surge * wrench_surge;
    assign p1_next = c_sway  * wrench_sway;
    assign p2_next = c_yaw   * wrench_yaw;

    always_ff @(posedge clk)
    begin
        if (ctl.s1)
        begin
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            prev1_reg <= prev_thrust;
        end
    end

    // stage 2: sum, round half up, shift by 16, saturate
    logic signed [SUM_W-1:0] sum;
    logic signed [SH_W-1:0]  sh;
    thrust_t t_next, t_reg, prev2_reg;

    always_comb
    begin
        sum = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg) + ROUND_HALF;
        sh  = signed'(sum[SUM_W-1:16]);
        if (sh > SH_W'(THRUST_MAX))
            t_next = THRUST_MAX;
        else if (sh < SH_W'(THRUST_MIN))
            t_next = THRUST_MIN;
        else
            t_next = sh[THRUST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s2)
        begin
            t_reg     <= t_next;
            prev2_reg <= prev1_reg;
        end
    end

    // stage 3: rate limit, result may leave 24 bits
    logic signed [DLT_W-1:0] delta, lim;
    logic signed [RL_W-1:0]  r_next, r_reg;
    logic                    rate_hit_next, rate_hit_reg;

    always_comb
    begin
        delta = DLT_W'(t_reg) - DLT_W'(prev2_reg);
        lim   = signed'({2'b00, limits.rate_limit});
        rate_hit_next = 1'b0;
        if (delta > lim)
        begin
            r_next        = RL_W'(prev2_reg) + RL_W'(lim);
            rate_hit_next = 1'b1;
        end
        else if (delta < -lim)
        begin
            r_next        = RL_W'(prev2_reg) - RL_W'(lim);
            rate_hit_next = 1'b1;
        end
        else
        begin
            r_next = RL_W'(t_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s3)
        begin
            r_reg        <= r_next;
            rate_hit_reg <= rate_hit_next;
        end
    end

    // stage 4: box clamp, floor checked first
    logic signed [RL_W-1:0] c_ext;
    logic                   box_hit;
    thrust_t                thrust_next, thrust_reg;
    logic [1:0]             cnt_reg;

    always_comb
    begin
        if (r_reg < RL_W'(limits.floor))
            c_ext = RL_W'(limits.floor);
        else if (r_reg > RL_W'(limits.ceiling))
            c_ext = RL_W'(limits.ceiling);
        else
            c_ext = r_reg;
        box_hit     = (c_ext != r_reg);
        thrust_next = c_ext[THRUST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s4)
        begin
            thrust_reg <= thrust_next;
            cnt_reg    <= {1'b0, rate_hit_reg} + {1'b0, box_hit};
        end
    end

    assign thrust  = thrust_reg;
    assign sat_cnt = cnt_reg;

endmodule

[rtl/rate_limited_thrust_allocator.sv]
// ----------------------------------------------------------------------------
// rate_limited_thrust_allocator
// Pseudo-inverse thrust allocation with per-step rate limit and box clamp.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid / in_stall    | wrench_surge/sway/yaw, prev_thrust_0..3
//  output   | out_valid / out_stall  | thrust_0..3, saturation_count
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One item per cycle unless out_stall backs the pipe up; the stages are
//  products, rounded sum, rate limit, clamp and the count/output register.
//  Stages advance independently: a held output fills bubbles first, and
//  in_stall rises only once all five stages hold items.
//  Reset clears the stage valid bits and loads the register defaults.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module rate_limited_thrust_allocator #(
    parameter int THRUSTER_COUNT = rta_pkg::THRUSTER_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rta_pkg::thrust_t                wrench_surge,
    input  rta_pkg::thrust_t                wrench_sway,
    input  rta_pkg::thrust_t                wrench_yaw,
    input  rta_pkg::thrust_t                prev_thrust_0,
    input  rta_pkg::thrust_t                prev_thrust_1,
    input  rta_pkg::thrust_t                prev_thrust_2,
    input  rta_pkg::thrust_t                prev_thrust_3,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rta_pkg::thrust_t                thrust_0,
    output rta_pkg::thrust_t                thrust_1,
    output rta_pkg::thrust_t                thrust_2,
    output rta_pkg::thrust_t                thrust_3,
    output logic [rta_pkg::SAT_CNT_W-1:0]   saturation_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rta_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rta_pkg::*;

    // pipeline control
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES:0]   en;
    pipe_ctl_t              ctl;

    always_comb
    begin
        en[PIPE_STAGES] = !out_stall;
        for (int k = PIPE_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_STAGES; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign ctl.s1    = en[0];
    assign ctl.s2    = en[1];
    assign ctl.s3    = en[2];
    assign ctl.s4    = en[3];
    assign in_stall  = !en[0];
    assign out_valid = vld_reg[PIPE_STAGES-1];
    assign cfg_ready = 1'b1;

    // configuration
    limits_t   limits;
    coef_row_t coef_rows [MAX_THRUSTERS];

    rta_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_valid && cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .limits    (limits),
        .coef_rows (coef_rows)
    );

    // lanes
    thrust_t    prev_arr  [MAX_THRUSTERS];
    thrust_t    lane_thr  [MAX_THRUSTERS];
    logic [1:0] lane_cnt  [MAX_THRUSTERS];

    assign prev_arr[0] = prev_thrust_0;
    assign prev_arr[1] = prev_thrust_1;
    assign prev_arr[2] = prev_thrust_2;
    assign prev_arr[3] = prev_thrust_3;

    for (genvar i = 0; i < MAX_THRUSTERS; i++)
    begin : g_lane
        if (i < THRUSTER_COUNT)
        begin : g_on
            rta_lane u_lane (
                .clk          (clk),
                .ctl          (ctl),
                .coef_row     (coef_rows[i]),
                .limits       (limits),
                .wrench_surge (wrench_surge),
                .wrench_sway  (wrench_sway),
                .wrench_yaw   (wrench_yaw),
                .prev_thrust  (prev_arr[i]),
                .thrust       (lane_thr[i]),
                .sat_cnt      (lane_cnt[i])
            );
        end
        else
        begin : g_off
            assign lane_thr[i] = '0;
            assign lane_cnt[i] = '0;
        end
    end

    // output stage: per-thruster counts summed here
    logic [SAT_CNT_W-1:0] cnt_next, cnt_reg;
    thrust_t              thr_reg [MAX_THRUSTERS];

    always_comb
    begin
        cnt_next = '0;
        for (int i = 0; i < MAX_THRUSTERS; i++)
        begin
            cnt_next = cnt_next + SAT_CNT_W'(lane_cnt[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[PIPE_STAGES-1])
        begin
            cnt_reg <= cnt_next;
            for (int i = 0; i < MAX_THRUSTERS; i++)
            begin
                thr_reg[i] <= lane_thr[i];
            end
        end
    end

    assign thrust_0         = thr_reg[0];
    assign thrust_1         = thr_reg[1];
    assign thrust_2         = thr_reg[2];
    assign thrust_3         = thr_reg[3];
    assign saturation_count = cnt_reg;

endmodule

[rtl/rta_chk.sv]
// ----------------------------------------------------------------------------
// rta_chk
// Port-level checks for the thrust allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rate_limited_thrust_allocator_macros.svh"

module rta_chk #(
    parameter int THRUSTER_COUNT = rta_pkg::THRUSTER_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  rta_pkg::thrust_t                thrust_0,
    input  rta_pkg::thrust_t                thrust_1,
    input  rta_pkg::thrust_t                thrust_2,
    input  rta_pkg::thrust_t                thrust_3,
    input  logic [rta_pkg::SAT_CNT_W-1:0]   saturation_count
);
    import rta_pkg::*;

    localparam logic [SAT_CNT_W-1:0] CNT_LIMIT = SAT_CNT_W'(2 * THRUSTER_COUNT);

    // a held result stays put
    `RTA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable({thrust_0, thrust_1, thrust_2, thrust_3, saturation_count}), "output changed while stalled")

    // input backs up only when the whole pipe is full behind a held output
    `RTA_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall, "input stalled with room in pipe")

    // two saturation sources per active thruster at most
    `RTA_ASSERT(a_cnt_range, out_valid |-> saturation_count <= CNT_LIMIT, "saturation count out of range")

    // no result in or right out of reset
    `RTA_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid && !in_stall, "pipe not empty in reset")

endmodule

bind rate_limited_thrust_allocator rta_chk #(.THRUSTER_COUNT(THRUSTER_COUNT)) u_rta_chk (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb : rate limited thrust allocator testbench
// Streams wrench commands through the allocator and checks every result
// against an in-bench model of the dot product, rounding, rate limit and box
// clamp. Coefficient rows and limits are rewritten between phases while the
// pipeline is empty; both channels stall at random except in the last phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rta_pkg::*;

    localparam int N_THRUSTERS     = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SWEEP_PHASES    = 10;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int BURST_ITEMS     = 280;
    localparam int MAX_REPORTS     = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam coef_row_t ROW_ZERO = '0;

    typedef struct packed {
        thrust_t       surge;
        thrust_t       sway;
        thrust_t       yaw;
        thrust_t [3:0] prev;
    } wrench_cmd_t;

    typedef struct packed {
        thrust_t [3:0]        thrust;
        logic [SAT_CNT_W-1:0] sat_hits;
    } allocation_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    thrust_t                wrench_surge;
    thrust_t                wrench_sway;
    thrust_t                wrench_yaw;
    thrust_t                prev_thrust_0;
    thrust_t                prev_thrust_1;
    thrust_t                prev_thrust_2;
    thrust_t                prev_thrust_3;
    logic                   out_valid;
    logic                   out_stall;
    thrust_t                thrust_0;
    thrust_t                thrust_1;
    thrust_t                thrust_2;
    thrust_t                thrust_3;
    logic [SAT_CNT_W-1:0]   saturation_count;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // shadow copy of the allocator registers
    rate_t       cur_rate;
    thrust_t     cur_floor;
    thrust_t     cur_ceiling;
    coef_row_t   cur_rows [MAX_THRUSTERS];

    allocation_t pending_allocs [$];
    bit          no_idle;
    int          mismatches;
    int          n_sent;
    int          n_results;
    int          n_writes;
    longint      sat_total;
    int          idle_cycles;

    rate_limited_thrust_allocator #(
        .THRUSTER_COUNT (N_THRUSTERS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .wrench_surge     (wrench_surge),
        .wrench_sway      (wrench_sway),
        .wrench_yaw       (wrench_yaw),
        .prev_thrust_0    (prev_thrust_0),
        .prev_thrust_1    (prev_thrust_1),
        .prev_thrust_2    (prev_thrust_2),
        .prev_thrust_3    (prev_thrust_3),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .thrust_0         (thrust_0),
        .thrust_1         (thrust_1),
        .thrust_2         (thrust_2),
        .thrust_3         (thrust_3),
        .saturation_count (saturation_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Allocation model
    // ------------------------------------------------------------------------

    // dot product, round half up, shift by 16, saturate to 24 bits
    function automatic longint unconstrained_thrust(coef_row_t row, wrench_cmd_t cmd);
        longint  acc;
        coef_t   cf;
        thrust_t wv [3];
        wv[0] = cmd.surge;
        wv[1] = cmd.sway;
        wv[2] = cmd.yaw;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            cf = row[k*COEF_W +: COEF_W];
            acc += longint'(cf) * longint'(wv[k]);
        end
        acc = (acc + 32768) >>> 16;
        if (acc > longint'(THRUST_MAX))
            acc = longint'(THRUST_MAX);
        if (acc < longint'(THRUST_MIN))
            acc = longint'(THRUST_MIN);
        return acc;
    endfunction

    function automatic allocation_t predict_allocation(wrench_cmd_t cmd);
        allocation_t res;
        longint      t;
        longint      prev;
        longint      delta;
        longint      lim;
        longint      c;
        thrust_t     p;
        int          hits;
        res  = '0;
        hits = 0;
        lim  = longint'(cur_rate);
        for (int i = 0; i < MAX_THRUSTERS; i++)
        begin
            if (i < N_THRUSTERS)
            begin
                t     = unconstrained_thrust(cur_rows[i], cmd);
                p     = cmd.prev[i];
                prev  = longint'(p);
                delta = t - prev;
                if (delta > lim)
                begin
                    t = prev + lim;
                    hits++;
                end
                if (delta < -lim)
                begin
                    t = prev - lim;
                    hits++;
                end
                // floor wins when floor is above ceiling
                if (t < longint'(cur_floor))
                    c = longint'(cur_floor);
                else if (t > longint'(cur_ceiling))
                    c = longint'(cur_ceiling);
                else
                    c = t;
                if (c != t)
                    hits++;
                res.thrust[i] = c[THRUST_W-1:0];
            end
        end
        res.sat_hits = hits[SAT_CNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic wrench_cmd_t cmd_of(thrust_t s, thrust_t w, thrust_t y, thrust_t p0,
                                           thrust_t p1, thrust_t p2, thrust_t p3);
        wrench_cmd_t cmd;
        cmd.surge   = s;
        cmd.sway    = w;
        cmd.yaw     = y;
        cmd.prev[0] = p0;
        cmd.prev[1] = p1;
        cmd.prev[2] = p2;
        cmd.prev[3] = p3;
        return cmd;
    endfunction

    function automatic thrust_t pick_value();
        thrust_t v;
        case ($urandom_range(0, 7))
            0: v = THRUST_MAX;
            1: v = THRUST_MIN;
            default:
            begin
                v = thrust_t'($urandom);
                v = v >>> $urandom_range(0, 23);
            end
        endcase
        return v;
    endfunction

    function automatic coef_row_t pick_row();
        coef_row_t row;
        coef_t     cf;
        row = '0;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 5))
                0: cf = 18'sh1FFFF;
                1: cf = 18'sh20000;
                default:
                begin
                    cf = coef_t'($urandom);
                    cf = cf >>> $urandom_range(0, 17);
                end
            endcase
            row[k*COEF_W +: COEF_W] = cf;
        end
        return row;
    endfunction

    // prev thrusts are often placed near the unconstrained thrust so that
    // the rate limit and the box clamp both pass and bite
    function automatic wrench_cmd_t make_random_cmd();
        wrench_cmd_t cmd;
        longint      t;
        longint      span;
        longint      p;
        cmd       = '0;
        cmd.surge = pick_value();
        cmd.sway  = pick_value();
        cmd.yaw   = pick_value();
        for (int i = 0; i < MAX_THRUSTERS; i++)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                t    = unconstrained_thrust(cur_rows[i], cmd);
                span = ($urandom_range(0, 1) == 1) ? longint'(cur_rate) + 1
                                                   : longint'($urandom_range(0, 64));
                p    = t + longint'($urandom_range(0, 32'(2 * span))) - span;
                if (p > longint'(THRUST_MAX))
                    p = longint'(THRUST_MAX);
                if (p < longint'(THRUST_MIN))
                    p = longint'(THRUST_MIN);
                cmd.prev[i] = p[THRUST_W-1:0];
            end
            else
            begin
                cmd.prev[i] = pick_value();
            end
        end
        return cmd;
    endfunction

    task automatic send_cmd(input wrench_cmd_t cmd);
        int gap;
        gap = (!no_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        wrench_surge  <= cmd.surge;
        wrench_sway   <= cmd.sway;
        wrench_yaw    <= cmd.yaw;
        prev_thrust_0 <= cmd.prev[0];
        prev_thrust_1 <= cmd.prev[1];
        prev_thrust_2 <= cmd.prev[2];
        prev_thrust_3 <= cmd.prev[3];
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        pending_allocs.push_back(predict_allocation(cmd));
        n_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_RATE_LIMIT: cur_rate    = data[RATE_W-1:0];
            REG_FLOOR:      cur_floor   = data[THRUST_W-1:0];
            REG_CEILING:    cur_ceiling = data[THRUST_W-1:0];
            REG_COEF_ROW_0: cur_rows[0] = data;
            REG_COEF_ROW_1: cur_rows[1] = data;
            REG_COEF_ROW_2: cur_rows[2] = data;
            REG_COEF_ROW_3: cur_rows[3] = data;
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits beyond a narrow register carry junk
    task automatic set_limits(input rate_t r, input thrust_t f, input thrust_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'({$urandom, $urandom});
        write_reg(REG_RATE_LIMIT, {junk[CFG_DATA_W-1:RATE_W], r});
        junk = CFG_DATA_W'({$urandom, $urandom});
        write_reg(REG_FLOOR, {junk[CFG_DATA_W-1:THRUST_W], f});
        junk = CFG_DATA_W'({$urandom, $urandom});
        write_reg(REG_CEILING, {junk[CFG_DATA_W-1:THRUST_W], c});
    endtask

    task automatic set_rows(input coef_row_t r0, input coef_row_t r1, input coef_row_t r2,
                            input coef_row_t r3);
        write_reg(REG_COEF_ROW_0, r0);
        write_reg(REG_COEF_ROW_1, r1);
        write_reg(REG_COEF_ROW_2, r2);
        write_reg(REG_COEF_ROW_3, r3);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // zero rows after reset; a prev at the bottom rail exceeds the full rate
    task automatic test_reset_defaults();
        send_cmd(cmd_of(0, 0, 0, 0, 0, 0, 0));
        send_cmd(cmd_of(THRUST_MAX, THRUST_MIN, 12345, THRUST_MIN, THRUST_MIN,
                        THRUST_MIN, THRUST_MIN));
        send_cmd(cmd_of(THRUST_MIN, THRUST_MAX, -1, THRUST_MAX, THRUST_MAX, -1, 1));
        wait_drained();
    endtask

    // unit coefficients expose round-half-up at both signs
    task automatic test_rounding();
        set_rows({18'h00000, 18'h00000, 18'h00001},
                 {18'h00000, 18'h3FFFF, 18'h00000},
                 {18'h00001, 18'h00000, 18'h00000},
                 {18'h00001, 18'h00001, 18'h00001});
        send_cmd(cmd_of(32768, 32768, -32768, 0, 0, 0, 0));
        send_cmd(cmd_of(-32768, -32768, 98304, 0, 0, 0, 0));
        send_cmd(cmd_of(98304, -98304, -98304, 0, 0, 0, 0));
        send_cmd(cmd_of(32767, 32769, -32769, 0, 0, 0, 0));
        wait_drained();
    endtask

    // index 7 is not a register and must leave every row alone
    task automatic test_unused_index();
        write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
        send_cmd(cmd_of(65536, -65536, 131072, 1, 2, 3, 4));
        send_cmd(make_random_cmd());
        wait_drained();
    endtask

    // largest coefficients against the widest wrench: sum saturates to 24 bits
    task automatic test_dot_saturation();
        set_rows({18'h1FFFF, 18'h1FFFF, 18'h1FFFF},
                 {18'h20000, 18'h20000, 18'h20000},
                 {18'h1FFFF, 18'h20000, 18'h1FFFF},
                 pick_row());
        send_cmd(cmd_of(THRUST_MAX, THRUST_MAX, THRUST_MAX, THRUST_MAX, THRUST_MIN,
                        THRUST_MAX, 0));
        send_cmd(cmd_of(THRUST_MIN, THRUST_MIN, THRUST_MIN, THRUST_MIN, THRUST_MAX,
                        THRUST_MIN, 0));
        send_cmd(cmd_of(THRUST_MAX, THRUST_MIN, THRUST_MAX, THRUST_MIN, THRUST_MIN,
                        THRUST_MAX, THRUST_MIN));
        send_cmd(cmd_of(THRUST_MIN, THRUST_MAX, THRUST_MIN, THRUST_MAX, THRUST_MAX,
                        THRUST_MIN, THRUST_MAX));
        wait_drained();
    endtask

    // rows pass surge, sway, yaw and minus surge straight through
    task automatic test_limit_corners();
        set_rows({18'h00000, 18'h00000, 18'h10000},
                 {18'h00000, 18'h10000, 18'h00000},
                 {18'h10000, 18'h00000, 18'h00000},
                 {18'h00000, 18'h00000, 18'h30000});
        set_limits('0, THRUST_MIN, THRUST_MAX);
        send_cmd(cmd_of(1000, -1000, 0, 5, -5, 0, THRUST_MIN));
        wait_drained();
        set_limits(23'd100, THRUST_MIN, THRUST_MAX);
        send_cmd(cmd_of(1000, -1000, 50, 0, 0, 0, 0));
        send_cmd(cmd_of(1000, -1000, 50, 950, -900, 150, -1100));
        wait_drained();
        // floor above ceiling
        set_limits(RATE_MAX, 24'sd100, -24'sd100);
        send_cmd(cmd_of(50, -500, 500, 50, -500, 500, 0));
        wait_drained();
        set_limits(RATE_MAX, 24'sd7, 24'sd7);
        send_cmd(cmd_of(7, -3, 9000, 7, -3, 9000, -7));
        wait_drained();
        set_limits(RATE_MAX, -24'sd1000, 24'sd1000);
        send_cmd(cmd_of(999, 1000, 1001, 999, 1000, 1001, -999));
        send_cmd(cmd_of(-999, -1000, -1001, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_random_sweep();
        rate_t   r;
        thrust_t a;
        thrust_t b;
        for (int ph = 0; ph < SWEEP_PHASES; ph++)
        begin
            r = rate_t'($urandom) >> $urandom_range(0, 22);
            a = pick_value();
            b = pick_value();
            case (ph)
                0: set_limits('0, THRUST_MIN, THRUST_MAX);
                1: set_limits(RATE_MAX, THRUST_MIN, THRUST_MAX);
                2: set_limits(r, (a > b) ? a : b, (a > b) ? b : a);
                3: set_limits(r, a, a);
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        set_limits(r, a, b);
                    else
                        set_limits(r, (a < b) ? a : b, (a < b) ? b : a);
                end
            endcase
            if (ph == 0)
                set_rows(ROW_ZERO, pick_row(), pick_row(), pick_row());
            else
                set_rows(pick_row(), pick_row(), pick_row(), pick_row());
            repeat (ITEMS_PER_PHASE) send_cmd(make_random_cmd());
            wait_drained();
        end
    endtask

    // full rate: no gaps on the input, no stalls on the output
    task automatic test_back_to_back();
        no_idle = 1'b1;
        set_limits(rate_t'($urandom) >> $urandom_range(0, 12), -24'sd3000000, 24'sd3000000);
        set_rows(pick_row(), pick_row(), pick_row(), pick_row());
        repeat (BURST_ITEMS) send_cmd(make_random_cmd());
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        wrench_surge  = '0;
        wrench_sway   = '0;
        wrench_yaw    = '0;
        prev_thrust_0 = '0;
        prev_thrust_1 = '0;
        prev_thrust_2 = '0;
        prev_thrust_3 = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        no_idle       = 1'b0;
        mismatches    = 0;
        n_sent        = 0;
        n_results     = 0;
        n_writes      = 0;
        sat_total     = 0;
        cur_rate      = RATE_MAX;
        cur_floor     = THRUST_MIN;
        cur_ceiling   = THRUST_MAX;
        for (int i = 0; i < MAX_THRUSTERS; i++)
            cur_rows[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_rounding();
        test_unused_index();
        test_dot_saturation();
        test_limit_corners();
        test_random_sweep();
        test_back_to_back();

        repeat (10) @(posedge clk);
        $display("covered %0d wrench commands and %0d register writes,", n_sent, n_writes);
        $display("checked %0d allocations carrying %0d saturations", n_results, sat_total);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // output back-pressure in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string field, input longint expv, input longint actv);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expv, actv);
    endtask

    always @(posedge clk)
    begin
        allocation_t want;
        allocation_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.thrust[0] = thrust_0;
            got.thrust[1] = thrust_1;
            got.thrust[2] = thrust_2;
            got.thrust[3] = thrust_3;
            got.sat_hits  = saturation_count;
            n_results++;
            if (pending_allocs.size() == 0)
            begin
                mismatches++;
                $display("%0t: result transfer with nothing expected", $time);
            end
            else
            begin
                want = pending_allocs.pop_front();
                for (int i = 0; i < MAX_THRUSTERS; i++)
                    if (got.thrust[i] !== want.thrust[i])
                        report_mismatch($sformatf("thrust_%0d", i),
                                        $signed(want.thrust[i]), $signed(got.thrust[i]));
                if (got.sat_hits !== want.sat_hits)
                    report_mismatch("saturation_count", want.sat_hits, got.sat_hits);
                sat_total += got.sat_hits;
            end
        end
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_allocs.size());
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
